// File: rtl/ogcu_pkg.sv
package ogcu_pkg;

  // default grid limits
  localparam int unsigned MAX_ROWS_DEF = 512;
  localparam int unsigned MAX_COLS_DEF = 512;

  // field widths
  localparam int unsigned COORD_W = 9;
  localparam int unsigned DIM_W   = 10;
  localparam int unsigned CNT_W   = 19;
  localparam int unsigned CIDX_W  = 8;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_ROW_COUNT = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_COL_COUNT = 8'd1;

  // neighbour order: right, left, down, up
  localparam logic [1:0] NB_RIGHT = 2'd0;
  localparam logic [1:0] NB_LEFT  = 2'd1;
  localparam logic [1:0] NB_DOWN  = 2'd2;
  localparam logic [1:0] NB_UP    = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic rd_cell;
    logic mark_already;
    logic init_cell;
    logic rd_nb;
    logic next_nb;
    logic start_find;
    logic rd_cur;
    logic take_root;
    logic step;
    logic wr_a;
    logic wr_b;
    logic done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic oor;
    logic occ;
    logic nb_valid;
    logic last_nb;
    logic is_root;
    logic phase;
    logic same_root;
  } sts_t;

endpackage

// File: rtl/online_grid_component_union_core.sv
// Flow: an out-of-range cell passes ST_CELL_RD and ST_DONE, an already-set cell
// ST_CELL_RD, ST_CELL_CHK and ST_DONE; a new cell adds up to four neighbour unions,
// each parent step ST_F_RD then ST_F_CHK on the single memory port.
// Throughput: one item at a time; start is taken again while done_o is high.
// Reset: asynchronous; then a sweep clears all MAX_ROWS*MAX_COLS grid memory words
// with busy high. Config writes are taken at any time; done_o lasts one cycle, no stall.
module online_grid_component_union_core
  import ogcu_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CIDX_W-1:0]  cfg_index_i,
  input  logic [DIM_W-1:0]   cfg_data_i,
  output logic               done_o,
  output logic               already_set_o,
  output logic               out_of_range_o,
  output logic [CNT_W-1:0]   component_count_o,
  output logic [CNT_W-1:0]   largest_area_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ogcu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ogcu_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .row_i             (row_i),
    .col_i             (col_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .done_o            (done_o),
    .already_set_o     (already_set_o),
    .out_of_range_o    (out_of_range_o),
    .component_count_o (component_count_o),
    .largest_area_o    (largest_area_o)
  );

endmodule

// File: rtl/ogcu_ram.sv
module ogcu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, read first, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: rtl/ogcu_ctrl.sv
module ogcu_ctrl
  import ogcu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [10:0] {
    ST_CLEAR    = 11'b000_0000_0001,
    ST_IDLE     = 11'b000_0000_0010,
    ST_CELL_RD  = 11'b000_0000_0100,
    ST_CELL_CHK = 11'b000_0000_1000,
    ST_NB_SEL   = 11'b000_0001_0000,
    ST_NB_CHK   = 11'b000_0010_0000,
    ST_F_RD     = 11'b000_0100_0000,
    ST_F_CHK    = 11'b000_1000_0000,
    ST_JOIN_A   = 11'b001_0000_0000,
    ST_JOIN_B   = 11'b010_0000_0000,
    ST_DONE     = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CELL_RD;
        end
      end
      ST_CELL_RD: begin
        if (sts_i.oor) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd_cell = 1'b1;
          state_d       = ST_CELL_CHK;
        end
      end
      ST_CELL_CHK: begin
        if (sts_i.occ) begin
          cmd_o.mark_already = 1'b1;
          state_d            = ST_DONE;
        end else begin
          cmd_o.init_cell = 1'b1;
          state_d         = ST_NB_SEL;
        end
      end
      ST_NB_SEL: begin
        if (sts_i.nb_valid) begin
          cmd_o.rd_nb = 1'b1;
          state_d     = ST_NB_CHK;
        end else begin
          cmd_o.next_nb = 1'b1;
          state_d       = sts_i.last_nb ? ST_DONE : ST_NB_SEL;
        end
      end
      ST_NB_CHK: begin
        if (sts_i.occ) begin
          cmd_o.start_find = 1'b1;
          state_d          = ST_F_RD;
        end else begin
          cmd_o.next_nb = 1'b1;
          state_d       = sts_i.last_nb ? ST_DONE : ST_NB_SEL;
        end
      end
      ST_F_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = ST_F_CHK;
      end
      ST_F_CHK: begin
        if (sts_i.is_root) begin
          cmd_o.take_root = 1'b1;
          state_d         = sts_i.phase ? ST_JOIN_A : ST_F_RD;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_F_RD;
        end
      end
      ST_JOIN_A: begin
        if (sts_i.same_root) begin
          cmd_o.next_nb = 1'b1;
          state_d       = sts_i.last_nb ? ST_DONE : ST_NB_SEL;
        end else begin
          cmd_o.wr_a = 1'b1;
          state_d    = ST_JOIN_B;
        end
      end
      ST_JOIN_B: begin
        cmd_o.wr_b    = 1'b1;
        cmd_o.next_nb = 1'b1;
        state_d       = sts_i.last_nb ? ST_DONE : ST_NB_SEL;
      end
      ST_DONE: begin
        cmd_o.done = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/ogcu_dpath.sv
module ogcu_dpath
  import ogcu_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic               cfg_valid_i,
  input  logic [CIDX_W-1:0]  cfg_index_i,
  input  logic [DIM_W-1:0]   cfg_data_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic               done_o,
  output logic               already_set_o,
  output logic               out_of_range_o,
  output logic [CNT_W-1:0]   component_count_o,
  output logic [CNT_W-1:0]   largest_area_o
);

  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned SW    = $clog2(CELLS + 1);
  localparam int unsigned WW    = 1 + SW + AW;
  localparam int unsigned PW    = AW + DIM_W;

  // configuration registers
  logic [DIM_W-1:0] row_cnt_q, col_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= DIM_W'(512);
      col_cnt_q <= DIM_W'(512);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ROW_COUNT) row_cnt_q <= cfg_data_i;
      if (cfg_index_i == CFG_COL_COUNT) col_cnt_q <= cfg_data_i;
    end
  end

  // grid in use, clipped to the memory
  logic [DIM_W-1:0] rows_eff, cols_eff;
  always_comb begin
    rows_eff = (PW'(row_cnt_q) < PW'(MAX_ROWS)) ? row_cnt_q : DIM_W'(MAX_ROWS);
    cols_eff = (PW'(col_cnt_q) < PW'(MAX_COLS)) ? col_cnt_q : DIM_W'(MAX_COLS);
  end

  // item registers
  logic [COORD_W-1:0] r_q, c_q;
  logic [AW-1:0]      cell_q, cur_q, r1_q, r2_q;
  logic [SW-1:0]      s1_q, s2_q;
  logic [1:0]         k_q;
  logic               phase_q, oor_q, already_q;
  logic [PW-1:0]      prod;

  assign prod = PW'(row_i) * PW'(MAX_COLS) + PW'(col_i);

  // memory word: occupied, size, parent
  logic [WW-1:0] rdata, wdata;
  logic [AW-1:0] addr, clr_cnt_q, nb_addr, win, lose;
  logic          we;
  logic          r_occ;
  logic [SW-1:0] r_size, sum, lose_size;
  logic [AW-1:0] r_par;
  logic          gt;

  assign r_occ  = rdata[WW-1];
  assign r_size = rdata[AW +: SW];
  assign r_par  = rdata[AW-1:0];

  // neighbour select
  logic nb_valid;
  always_comb begin
    case (k_q)
      NB_RIGHT: begin
        nb_valid = (DIM_W'(c_q) + DIM_W'(1)) < cols_eff;
        nb_addr  = cell_q + AW'(1);
      end
      NB_LEFT: begin
        nb_valid = (c_q != '0);
        nb_addr  = cell_q - AW'(1);
      end
      NB_DOWN: begin
        nb_valid = (DIM_W'(r_q) + DIM_W'(1)) < rows_eff;
        nb_addr  = cell_q + AW'(MAX_COLS);
      end
      NB_UP: begin
        nb_valid = (r_q != '0);
        nb_addr  = cell_q - AW'(MAX_COLS);
      end
      default: begin
        nb_valid = 1'b0;
        nb_addr  = cell_q;
      end
    endcase
  end

  // union by size, ties go to the neighbour root
  assign sum       = s1_q + s2_q;
  assign gt        = s1_q > s2_q;
  assign win       = gt ? r1_q : r2_q;
  assign lose      = gt ? r2_q : r1_q;
  assign lose_size = gt ? s2_q : s1_q;

  // memory address and write data
  always_comb begin
    we    = cmd_i.clr | cmd_i.init_cell | cmd_i.wr_a | cmd_i.wr_b;
    wdata = '0;
    addr  = cur_q;
    if (cmd_i.clr) begin
      addr = clr_cnt_q;
    end else if (cmd_i.rd_cell || cmd_i.init_cell) begin
      addr  = cell_q;
      wdata = {1'b1, SW'(1), cell_q};
    end else if (cmd_i.rd_nb) begin
      addr = nb_addr;
    end else if (cmd_i.rd_cur) begin
      addr = cur_q;
    end else if (cmd_i.wr_a) begin
      addr  = win;
      wdata = {1'b1, sum, win};
    end else if (cmd_i.wr_b) begin
      addr  = lose;
      wdata = {1'b1, lose_size, win};
    end
  end

  ogcu_ram #(
    .WIDTH (WW),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // item and find registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      r_q    <= row_i;
      c_q    <= col_i;
      cell_q <= prod[AW-1:0];
    end
    if (cmd_i.start_find) begin
      cur_q <= cell_q;
    end else if (cmd_i.step) begin
      cur_q <= r_par;
    end else if (cmd_i.take_root && !phase_q) begin
      cur_q <= nb_addr;
    end
    if (cmd_i.take_root) begin
      if (!phase_q) begin
        r1_q <= cur_q;
        s1_q <= r_size;
      end else begin
        r2_q <= cur_q;
        s2_q <= r_size;
      end
    end
  end

  // control-side registers
  logic [SW-1:0] comps_q, largest_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      phase_q   <= 1'b0;
      oor_q     <= 1'b0;
      already_q <= 1'b0;
      comps_q   <= '0;
      largest_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        oor_q     <= ({1'b0, row_i} >= rows_eff) || ({1'b0, col_i} >= cols_eff);
        already_q <= 1'b0;
      end
      if (cmd_i.mark_already) already_q <= 1'b1;
      if (cmd_i.init_cell) begin
        k_q     <= NB_RIGHT;
        comps_q <= comps_q + SW'(1);
        if (largest_q == '0) largest_q <= SW'(1);
      end
      if (cmd_i.next_nb) k_q <= k_q + 2'd1;
      if (cmd_i.start_find) phase_q <= 1'b0;
      if (cmd_i.take_root) phase_q <= 1'b1;
      if (cmd_i.wr_a) begin
        comps_q <= comps_q - SW'(1);
        if (sum > largest_q) largest_q <= sum;
      end
    end
  end

  // status
  always_comb begin
    sts_o.clr_last  = (clr_cnt_q == AW'(CELLS - 1));
    sts_o.oor       = oor_q;
    sts_o.occ       = r_occ;
    sts_o.nb_valid  = nb_valid;
    sts_o.last_nb   = (k_q == NB_UP);
    sts_o.is_root   = (r_par == cur_q);
    sts_o.phase     = phase_q;
    sts_o.same_root = (r1_q == r2_q);
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      already_set_o     <= already_q;
      out_of_range_o    <= oor_q;
      component_count_o <= CNT_W'(comps_q);
      largest_area_o    <= CNT_W'(largest_q);
    end
  end

  // checks
  a_wrb_after_wra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_b |-> $past(cmd_i.wr_a)) else $error("second join write without first");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.done |-> !(already_q && oor_q)) else $error("both result flags set");
  a_join_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_a |-> (r1_q != r2_q)) else $error("join of a root with itself");
  a_init_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.init_cell |-> !oor_q) else $error("out of range cell written");

endmodule
